// ===== rtl/ntc_pkg.sv =====
package ntc_pkg;

  localparam int TABLE_ROWS    = 101;
  localparam int ADC_BITS      = 10;
  localparam int FRACTION_BITS = 4;
  localparam int TEMP_W        = 12;
  localparam int STORED_ROWS   = 101;
  localparam int ROW_OFFSET    = 30;

  localparam int ROWS_USED = (TABLE_ROWS > STORED_ROWS) ? STORED_ROWS : TABLE_ROWS;
  localparam int ROW_W     = (ROWS_USED > 1) ? $clog2(ROWS_USED) : 1;
  localparam int QUO_W     = FRACTION_BITS + 1;

  // lower and upper code of each one-degree band, -30 C first
  localparam logic [15:0] BAND_LO_TBL [STORED_ROWS] = '{
    16'd958, 16'd955, 16'd951, 16'd948, 16'd944, 16'd940, 16'd936, 16'd932, 16'd927, 16'd922,
    16'd917, 16'd912, 16'd907, 16'd902, 16'd896, 16'd890, 16'd884, 16'd878, 16'd871, 16'd864,
    16'd857, 16'd850, 16'd843, 16'd835, 16'd827, 16'd819, 16'd811, 16'd803, 16'd794, 16'd785,
    16'd776, 16'd767, 16'd757, 16'd748, 16'd738, 16'd728, 16'd718, 16'd708, 16'd697, 16'd687,
    16'd676, 16'd665, 16'd654, 16'd640, 16'd631, 16'd620, 16'd608, 16'd597, 16'd586, 16'd574,
    16'd565, 16'd554, 16'd540, 16'd529, 16'd517, 16'd506, 16'd496, 16'd485, 16'd475, 16'd464,
    16'd453, 16'd442, 16'd432, 16'd421, 16'd411, 16'd400, 16'd390, 16'd380, 16'd370, 16'd360,
    16'd351, 16'd342, 16'd332, 16'd323, 16'd315, 16'd306, 16'd297, 16'd289, 16'd281, 16'd273,
    16'd266, 16'd258, 16'd250, 16'd243, 16'd236, 16'd229, 16'd223, 16'd216, 16'd210, 16'd204,
    16'd200, 16'd192, 16'd186, 16'd181, 16'd176, 16'd170, 16'd165, 16'd161, 16'd156, 16'd151,
    16'd147
  };

  localparam logic [15:0] BAND_HI_TBL [STORED_ROWS] = '{
    16'd963, 16'd957, 16'd954, 16'd950, 16'd947, 16'd943, 16'd939, 16'd935, 16'd931, 16'd926,
    16'd921, 16'd916, 16'd911, 16'd906, 16'd901, 16'd895, 16'd889, 16'd883, 16'd877, 16'd870,
    16'd863, 16'd856, 16'd849, 16'd842, 16'd834, 16'd826, 16'd818, 16'd810, 16'd802, 16'd793,
    16'd784, 16'd775, 16'd766, 16'd756, 16'd747, 16'd737, 16'd727, 16'd717, 16'd707, 16'd696,
    16'd686, 16'd675, 16'd664, 16'd655, 16'd639, 16'd630, 16'd619, 16'd607, 16'd596, 16'd585,
    16'd573, 16'd564, 16'd553, 16'd539, 16'd528, 16'd516, 16'd505, 16'd495, 16'd484, 16'd474,
    16'd463, 16'd452, 16'd441, 16'd431, 16'd420, 16'd410, 16'd399, 16'd389, 16'd379, 16'd369,
    16'd359, 16'd350, 16'd341, 16'd331, 16'd322, 16'd314, 16'd305, 16'd296, 16'd288, 16'd280,
    16'd272, 16'd265, 16'd257, 16'd249, 16'd242, 16'd235, 16'd228, 16'd222, 16'd215, 16'd209,
    16'd203, 16'd199, 16'd191, 16'd185, 16'd180, 16'd175, 16'd169, 16'd164, 16'd160, 16'd155,
    16'd150
  };

  localparam logic [ADC_BITS-1:0] CODE_TOP    = BAND_HI_TBL[0][ADC_BITS-1:0];
  localparam logic [ADC_BITS-1:0] CODE_BOTTOM = BAND_LO_TBL[ROWS_USED-1][ADC_BITS-1:0];

  function automatic logic [ADC_BITS-1:0] band_lo(input logic [ROW_W-1:0] idx);
    return BAND_LO_TBL[idx][ADC_BITS-1:0];
  endfunction

  function automatic logic [ADC_BITS-1:0] band_hi(input logic [ROW_W-1:0] idx);
    return BAND_HI_TBL[idx][ADC_BITS-1:0];
  endfunction

  // band search result handed to the divider
  typedef struct packed {
    logic [ROW_W-1:0]    row;
    logic [ADC_BITS-1:0] num;
    logic [ADC_BITS-1:0] den;
    logic                flag;
  } band_t;

  // divider result handed to the output stage
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [QUO_W-1:0] frac;
    logic             flag;
  } frac_t;

endpackage

// ===== rtl/ntc_if.sv =====
interface ntc_in_if;
  import ntc_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

interface ntc_out_if;
  import ntc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_q4;
  logic                     out_of_range;

  modport source (output valid, output temperature_q4, output out_of_range, input ready);
  modport sink   (input valid, input temperature_q4, input out_of_range, output ready);
endinterface

// ===== rtl/ntc_band_search.sv =====
module ntc_band_search (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ntc_pkg::ADC_BITS-1:0] in_code,
  output logic                out_valid,
  input  logic                out_ready,
  output ntc_pkg::band_t      out_band
);
  import ntc_pkg::*;

  // stage 1: clamp
  logic                v1_r;
  logic [ADC_BITS-1:0] c1_r, c1_nxt;
  logic                f1_r, f1_nxt;
  // stage 2: first-match row
  logic                v2_r;
  logic [ADC_BITS-1:0] c2_r;
  logic [ROW_W-1:0]    row2_r, row2_nxt;
  logic                f2_r;
  // stage 3: band operands
  logic                v3_r;
  band_t               band3_r, band3_nxt;

  logic rdy1, rdy2, rdy3;
  logic [ADC_BITS-1:0] hi, lo;
  logic                band_ok;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    c1_nxt = in_code;
    f1_nxt = 1'b0;
    if (in_code > CODE_TOP) begin
      c1_nxt = CODE_TOP;
      f1_nxt = 1'b1;
    end
    if (in_code < CODE_BOTTOM) begin
      c1_nxt = CODE_BOTTOM;
      f1_nxt = 1'b1;
    end
  end

  // lowest row whose lower bound is not above the code
  always_comb begin
    row2_nxt = ROW_W'(ROWS_USED - 1);
    for (int i = ROWS_USED - 1; i >= 0; i--) begin
      if (band_lo(ROW_W'(i)) <= c1_r) begin
        row2_nxt = ROW_W'(i);
      end
    end
  end

  always_comb begin
    hi      = band_hi(row2_r);
    lo      = band_lo(row2_r);
    band_ok = (hi > lo) && (c2_r <= hi);
    band3_nxt.row  = row2_r;
    band3_nxt.flag = f2_r;
    band3_nxt.num  = band_ok ? (hi - c2_r) : '0;
    band3_nxt.den  = band_ok ? (hi - lo) : ADC_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      c1_r <= c1_nxt;
      f1_r <= f1_nxt;
    end
    if (rdy2 && v1_r) begin
      c2_r   <= c1_r;
      f2_r   <= f1_r;
      row2_r <= row2_nxt;
    end
    if (rdy3 && v2_r) begin
      band3_r <= band3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_band  = band3_r;

endmodule

// ===== rtl/ntc_frac_div.sv =====
module ntc_frac_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ntc_pkg::band_t in_band,
  output logic           out_valid,
  input  logic           out_ready,
  output ntc_pkg::frac_t out_frac
);
  import ntc_pkg::*;

  localparam int STEPS = QUO_W;
  localparam int REM_W = ADC_BITS + 1;

  logic [STEPS-1:0]    vld_r;
  logic [STEPS:0]      rdy;
  logic [REM_W-1:0]    rem_r [STEPS];
  logic [ADC_BITS-1:0] den_r [STEPS];
  logic [QUO_W-1:0]    quo_r [STEPS];
  logic [ROW_W-1:0]    row_r [STEPS];
  logic [STEPS-1:0]    flag_r;

  assign rdy[STEPS] = out_ready;
  assign in_ready   = rdy[0];

  // one restoring quotient bit per stage, most significant first
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic                src_v;
    logic [REM_W-1:0]    src_rem;
    logic [ADC_BITS-1:0] src_den;
    logic [QUO_W-1:0]    src_quo;
    logic [ROW_W-1:0]    src_row;
    logic                src_flag;
    logic                ge;
    logic [REM_W-1:0]    rem_nxt;
    logic [QUO_W-1:0]    quo_nxt;

    if (k == 0) begin : g_first
      always_comb begin
        src_v    = in_valid;
        src_rem  = {1'b0, in_band.num};
        src_den  = in_band.den;
        src_quo  = '0;
        src_row  = in_band.row;
        src_flag = in_band.flag;
      end
    end else begin : g_next
      always_comb begin
        src_v    = vld_r[k-1];
        src_rem  = {rem_r[k-1][REM_W-2:0], 1'b0};
        src_den  = den_r[k-1];
        src_quo  = quo_r[k-1];
        src_row  = row_r[k-1];
        src_flag = flag_r[k-1];
      end
    end

    always_comb begin
      ge      = src_rem >= {1'b0, src_den};
      rem_nxt = ge ? (src_rem - {1'b0, src_den}) : src_rem;
      quo_nxt = (src_quo << 1) | QUO_W'(ge);
    end

    assign rdy[k] = !vld_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_v) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= src_den;
        quo_r[k]  <= quo_nxt;
        row_r[k]  <= src_row;
        flag_r[k] <= src_flag;
      end
    end
  end

  assign out_valid     = vld_r[STEPS-1];
  assign out_frac.row  = row_r[STEPS-1];
  assign out_frac.frac = quo_r[STEPS-1];
  assign out_frac.flag = flag_r[STEPS-1];

endmodule

// ===== rtl/ntc_table_search_temperature_unit.sv =====
// channel   dir  payload                              handshake
// in_chan   in   adc_code[9:0]                        valid/ready
// out_chan  out  temperature_q4[11:0] s, out_of_range valid/ready
//
// registered steps in order: clamp, band match, band operands, one divider
// stage per quotient bit, output register
// one beat per cycle unless stalled; every stage holds its own valid bit
// rst_n is synchronous and clears only the valid bits
// a stalled output fills the pipe from the back; no beat is dropped or repeated
module ntc_table_search_temperature_unit (
  input  logic clk,
  input  logic rst_n,
  ntc_in_if.sink    in_chan,
  ntc_out_if.source out_chan
);
  import ntc_pkg::*;

  // search front end -> divider
  logic  band_valid, band_ready;
  band_t band;

  // divider -> output register
  logic  frac_valid, frac_ready;
  frac_t frac;

  // output register
  logic              out_valid_r;
  logic [TEMP_W-1:0] temp_r, temp_nxt;
  logic              flag_r;
  logic [TEMP_W-1:0] degrees;

  ntc_band_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_code   (in_chan.adc_code),
    .out_valid (band_valid),
    .out_ready (band_ready),
    .out_band  (band)
  );

  ntc_frac_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (band_valid),
    .in_ready  (band_ready),
    .in_band   (band),
    .out_valid (frac_valid),
    .out_ready (frac_ready),
    .out_frac  (frac)
  );

  // whole degrees relative to -30 C, then scale and add the fraction
  always_comb begin
    degrees  = TEMP_W'(frac.row) - TEMP_W'(ROW_OFFSET);
    temp_nxt = (degrees << FRACTION_BITS) + TEMP_W'(frac.frac);
  end

  // output register frees the divider whenever the sink takes the beat
  assign frac_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (frac_ready) begin
      out_valid_r <= frac_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frac_ready && frac_valid) begin
      temp_r <= temp_nxt;
      flag_r <= frac.flag;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.temperature_q4 = $signed(temp_r);
  assign out_chan.out_of_range   = flag_r;

endmodule
